### rtl/lbd_pkg.sv
// ----------------------------------------------------------------------------
// lbd_pkg: shared types and constants
// Button codes, register indexes and the configuration bundle used by the
// ladder button debouncer.
// ----------------------------------------------------------------------------
package lbd_pkg;

  localparam int ADC_WIDTH  = 12;
  localparam int TIME_WIDTH = 32;
  localparam int HOLD_WIDTH = 16;
  localparam int IDX_WIDTH  = 3;
  localparam int DATA_WIDTH = 16;

  // button codes as reported on the result channel
  typedef enum logic [2:0] {
    CODE_NONE    = 3'd0,
    CODE_POWER   = 3'd1,
    CODE_RIGHT   = 3'd2,
    CODE_LEFT    = 3'd3,
    CODE_CONFIRM = 3'd4,
    CODE_BACK    = 3'd5,
    CODE_DOWN    = 3'd6,
    CODE_UP      = 3'd7
  } code_t;

  // configuration register indexes
  typedef enum logic [IDX_WIDTH-1:0] {
    REG_RIGHT   = 3'd0,
    REG_LEFT    = 3'd1,
    REG_CONFIRM = 3'd2,
    REG_BACK    = 3'd3,
    REG_DOWN    = 3'd4,
    REG_UP      = 3'd5,
    REG_HOLD    = 3'd6
  } reg_idx_t;

  // reset values of the registers
  localparam logic [ADC_WIDTH-1:0]  RIGHT_RESET   = 12'd103;
  localparam logic [ADC_WIDTH-1:0]  LEFT_RESET    = 12'd1570;
  localparam logic [ADC_WIDTH-1:0]  CONFIRM_RESET = 12'd2755;
  localparam logic [ADC_WIDTH-1:0]  BACK_RESET    = 12'd3570;
  localparam logic [ADC_WIDTH-1:0]  DOWN_RESET    = 12'd103;
  localparam logic [ADC_WIDTH-1:0]  UP_RESET      = 12'd2305;
  localparam logic [HOLD_WIDTH-1:0] HOLD_RESET    = 16'd50;

  // configuration bundle
  typedef struct packed {
    logic [ADC_WIDTH-1:0]  right_limit;
    logic [ADC_WIDTH-1:0]  left_limit;
    logic [ADC_WIDTH-1:0]  confirm_limit;
    logic [ADC_WIDTH-1:0]  back_limit;
    logic [ADC_WIDTH-1:0]  down_limit;
    logic [ADC_WIDTH-1:0]  up_limit;
    logic [HOLD_WIDTH-1:0] debounce_time;
  } cfg_t;

endpackage

### rtl/lbd_cfg_regs.sv
// ----------------------------------------------------------------------------
// lbd_cfg_regs: configuration registers
// Holds the six ladder limits and the debounce time, written by index.
// ----------------------------------------------------------------------------
module lbd_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [lbd_pkg::IDX_WIDTH-1:0]  cfg_index,
  input  logic [lbd_pkg::DATA_WIDTH-1:0] cfg_data,
  output lbd_pkg::cfg_t                cfg
);

  // indexed write, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.right_limit   <= lbd_pkg::RIGHT_RESET;
      cfg.left_limit    <= lbd_pkg::LEFT_RESET;
      cfg.confirm_limit <= lbd_pkg::CONFIRM_RESET;
      cfg.back_limit    <= lbd_pkg::BACK_RESET;
      cfg.down_limit    <= lbd_pkg::DOWN_RESET;
      cfg.up_limit      <= lbd_pkg::UP_RESET;
      cfg.debounce_time <= lbd_pkg::HOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        lbd_pkg::REG_RIGHT:   cfg.right_limit   <= cfg_data[lbd_pkg::ADC_WIDTH-1:0];
        lbd_pkg::REG_LEFT:    cfg.left_limit    <= cfg_data[lbd_pkg::ADC_WIDTH-1:0];
        lbd_pkg::REG_CONFIRM: cfg.confirm_limit <= cfg_data[lbd_pkg::ADC_WIDTH-1:0];
        lbd_pkg::REG_BACK:    cfg.back_limit    <= cfg_data[lbd_pkg::ADC_WIDTH-1:0];
        lbd_pkg::REG_DOWN:    cfg.down_limit    <= cfg_data[lbd_pkg::ADC_WIDTH-1:0];
        lbd_pkg::REG_UP:      cfg.up_limit      <= cfg_data[lbd_pkg::ADC_WIDTH-1:0];
        lbd_pkg::REG_HOLD:    cfg.debounce_time <= cfg_data[lbd_pkg::HOLD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/lbd_classify.sv
// ----------------------------------------------------------------------------
// lbd_classify: sample classifier
// Priority compare of the power pin and the two ladder readings.
// ----------------------------------------------------------------------------
module lbd_classify (
  input  lbd_pkg::cfg_t                 cfg,
  input  logic [lbd_pkg::ADC_WIDTH-1:0] ladder_one,
  input  logic [lbd_pkg::ADC_WIDTH-1:0] ladder_two,
  input  logic                          power_level,
  output lbd_pkg::code_t                code
);

  // power first, then channel one, then channel two
  always_comb begin
    if (!power_level)                         code = lbd_pkg::CODE_POWER;
    else if (ladder_one < cfg.right_limit)    code = lbd_pkg::CODE_RIGHT;
    else if (ladder_one < cfg.left_limit)     code = lbd_pkg::CODE_LEFT;
    else if (ladder_one < cfg.confirm_limit)  code = lbd_pkg::CODE_CONFIRM;
    else if (ladder_one < cfg.back_limit)     code = lbd_pkg::CODE_BACK;
    else if (ladder_two < cfg.down_limit)     code = lbd_pkg::CODE_DOWN;
    else if (ladder_two < cfg.up_limit)       code = lbd_pkg::CODE_UP;
    else                                      code = lbd_pkg::CODE_NONE;
  end

endmodule

### rtl/lbd_debounce.sv
// ----------------------------------------------------------------------------
// lbd_debounce: debounce state and result register
// Tracks the stable code and its start time, reports a held code once.
// ----------------------------------------------------------------------------
module lbd_debounce (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  lbd_pkg::code_t                 code,
  input  logic [lbd_pkg::TIME_WIDTH-1:0] now_ms,
  input  logic [lbd_pkg::HOLD_WIDTH-1:0] debounce_time,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [2:0]                     pressed_code
);

  lbd_pkg::code_t                 previous_code, previous_code_next;
  lbd_pkg::code_t                 reported_code, reported_code_next;
  logic [lbd_pkg::TIME_WIDTH-1:0] stable_start, stable_start_next;
  lbd_pkg::code_t                 result;
  logic [lbd_pkg::TIME_WIDTH-1:0] elapsed;
  logic                           held;

  // wrapping elapsed time against the hold time
  assign elapsed = now_ms - stable_start;
  assign held    = elapsed >= {{(lbd_pkg::TIME_WIDTH-lbd_pkg::HOLD_WIDTH){1'b0}}, debounce_time};

  // debounce decision
  always_comb begin
    previous_code_next = previous_code;
    stable_start_next  = stable_start;
    reported_code_next = reported_code;
    result             = lbd_pkg::CODE_NONE;
    if (code != previous_code) begin
      previous_code_next = code;
      stable_start_next  = now_ms;
    end else if (code != lbd_pkg::CODE_NONE && code != reported_code && held) begin
      reported_code_next = code;
      result             = code;
    end else if (code == lbd_pkg::CODE_NONE) begin
      reported_code_next = lbd_pkg::CODE_NONE;
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_code <= lbd_pkg::CODE_NONE;
      reported_code <= lbd_pkg::CODE_NONE;
      stable_start  <= '0;
    end else if (load) begin
      previous_code <= previous_code_next;
      reported_code <= reported_code_next;
      stable_start  <= stable_start_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pressed_code <= result;
    end
  end

  // a pending nonzero result always matches the last reported code
  a_result_reported: assert property (@(posedge clk) disable iff (rst)
    out_valid && pressed_code != lbd_pkg::CODE_NONE |-> pressed_code == reported_code)
    else $error("pending result differs from reported code");

  // a report only comes from a repeated code
  a_report_repeat: assert property (@(posedge clk) disable iff (rst)
    load && result != lbd_pkg::CODE_NONE |-> code == previous_code)
    else $error("report on a changed code");

  // a report leaves the previous code untouched
  a_report_keeps_prev: assert property (@(posedge clk) disable iff (rst)
    load && result != lbd_pkg::CODE_NONE |=> previous_code == $past(code))
    else $error("previous code moved on a report");

endmodule

### rtl/ladder_button_debouncer_unit.sv
// ----------------------------------------------------------------------------
// ladder_button_debouncer_unit: resistor ladder keypad debouncer
// Classifies ladder samples into button codes and reports held codes once.
// ----------------------------------------------------------------------------
// One sample enters per cycle while the result side does not stall, and each
// gives exactly one result: an input register feeds the classifier compare
// chain and the debounce check (one 32 bit subtract and compare), which load
// the result register. The input side stalls only when the result register
// is full and stalled. The result is the button code when it is reported and
// zero otherwise. Registers must be written by the user only while no sample
// is in flight; the block itself does not enforce it.
module ladder_button_debouncer_unit (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_write,
  input  logic [lbd_pkg::IDX_WIDTH-1:0]  cfg_index,
  input  logic [lbd_pkg::DATA_WIDTH-1:0] cfg_data,
  // sample channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lbd_pkg::ADC_WIDTH-1:0]  ladder_one,
  input  logic [lbd_pkg::ADC_WIDTH-1:0]  ladder_two,
  input  logic                           power_level,
  input  logic [lbd_pkg::TIME_WIDTH-1:0] now_ms,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     pressed_code
);

  lbd_pkg::cfg_t                  cfg;
  logic                           s1_valid;
  logic [lbd_pkg::ADC_WIDTH-1:0]  s1_one;
  logic [lbd_pkg::ADC_WIDTH-1:0]  s1_two;
  logic                           s1_power;
  logic [lbd_pkg::TIME_WIDTH-1:0] s1_now;
  lbd_pkg::code_t                 s1_code;
  logic                           load;

  lbd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // pipeline control
  assign load     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || load;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_one   <= ladder_one;
      s1_two   <= ladder_two;
      s1_power <= power_level;
      s1_now   <= now_ms;
    end
  end

  lbd_classify u_classify (
    .cfg         (cfg),
    .ladder_one  (s1_one),
    .ladder_two  (s1_two),
    .power_level (s1_power),
    .code        (s1_code)
  );

  lbd_debounce u_debounce (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .code          (s1_code),
    .now_ms        (s1_now),
    .debounce_time (cfg.debounce_time),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .pressed_code  (pressed_code)
  );

  // a held sample only waits on a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled without a stalled result");

endmodule
